### sv/fourier_sine_series_morph_synth_assert.svh
// assertion helpers shared by the synthesiser rtl
`ifndef FOURIER_SINE_SERIES_MORPH_SYNTH_ASSERT_SVH
`define FOURIER_SINE_SERIES_MORPH_SYNTH_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define FSSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define FSSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fssm_pkg.sv
`default_nettype none

package fssm_pkg;

  localparam int MAX_TERMS_DEF    = 32;
  localparam int SINE_ENTRIES_DEF = 256;

  localparam int COEF_W   = 16;
  localparam int FACTOR_W = 17;
  localparam int STEP_W   = 16;
  localparam int NTERMS_W = 6;
  localparam int PHASE_W  = 16;
  localparam int SAMPLE_W = 21;
  localparam int MUL_W    = 18;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'd65536;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  typedef enum logic [2:0] {
    CMD_LOAD_A = 3'd0,
    CMD_LOAD_B = 3'd1,
    CMD_SEL_A  = 3'd2,
    CMD_SEL_B  = 3'd3,
    CMD_TICK   = 3'd4,
    CMD_EVAL   = 3'd5
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_TERMS  = 2'd0,
    REG_MORPH_STEP = 2'd1,
    REG_ANIMATE    = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SWEEP = 2'd1,
    ST_DONE  = 2'd2
  } state_e;

  // write enables of the three coefficient tables
  typedef struct packed {
    logic a;
    logic b;
    logic c;
  } wr_en_t;

  // quarter-wave sine entry, Q1.15, from an angle in Q30 radians
  function automatic logic [15:0] sine_entry(input longint unsigned x);
    longint unsigned x2;
    longint unsigned s;
    longint unsigned v;
    x2 = (x * x) >> 30;
    s  = ONE_Q30 - x2 / 110;
    s  = ONE_Q30 - ((x2 * s) >> 30) / 72;
    s  = ONE_Q30 - ((x2 * s) >> 30) / 42;
    s  = ONE_Q30 - ((x2 * s) >> 30) / 20;
    s  = ONE_Q30 - ((x2 * s) >> 30) / 6;
    s  = (x * s) >> 30;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[15:0];
  endfunction

endpackage

`default_nettype wire

### sv/fssm_mul.sv
`default_nettype none

module fssm_mul (
  input  wire logic                                clk_i,
  input  wire logic signed [fssm_pkg::MUL_W-1:0]   a_i,
  input  wire logic signed [fssm_pkg::MUL_W-1:0]   b_i,
  output logic signed      [fssm_pkg::PROD_W-1:0]  prod_o
);

  logic signed [fssm_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

### sv/fssm_sine_rom.sv
`default_nettype none

module fssm_sine_rom #(
  parameter int SINE_TABLE_ENTRIES = fssm_pkg::SINE_ENTRIES_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic [fssm_pkg::PHASE_W-1:0]         phase_i,
  output logic signed [fssm_pkg::COEF_W-1:0]        sine_o
);

  localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1);

  logic [15:0] rom [SINE_TABLE_ENTRIES+1];

  for (genvar gi = 0; gi <= SINE_TABLE_ENTRIES; gi++) begin : g_rom
    localparam longint unsigned X =
      (64'(gi) * fssm_pkg::HALF_PI_Q30) / SINE_TABLE_ENTRIES;
    assign rom[gi] = fssm_pkg::sine_entry(X);
  end

  logic [1:0]  quad;
  logic [13:0] frac;
  logic [14:0] ang;
  logic [31:0] scaled;
  logic [IW-1:0] idx_q;
  logic          neg_q;
  logic signed [fssm_pkg::COEF_W-1:0] sine_q;
  logic signed [fssm_pkg::COEF_W-1:0] mag;

  // odd quadrants run the quarter table backwards
  always_comb begin
    quad   = phase_i[15:14];
    frac   = phase_i[13:0];
    ang    = quad[0] ? (15'd16384 - {1'b0, frac}) : {1'b0, frac};
    scaled = 32'(ang) * 32'(SINE_TABLE_ENTRIES);
    mag    = signed'(rom[idx_q]);
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= scaled[14 +: IW];
    neg_q  <= quad[1];
    sine_q <= neg_q ? -mag : mag;
  end

  assign sine_o = sine_q;

endmodule

`default_nettype wire

### sv/fssm_coef_store.sv
`default_nettype none

module fssm_coef_store #(
  parameter int MAX_TERMS = fssm_pkg::MAX_TERMS_DEF,
  parameter int AW        = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire fssm_pkg::wr_en_t                    wr_en_i,
  input  wire logic [AW-1:0]                       wr_addr_i,
  input  wire logic signed [fssm_pkg::COEF_W-1:0]  wr_data_i,
  input  wire logic [AW-1:0]                       rd_addr_i,
  output logic signed [fssm_pkg::COEF_W-1:0]       rd_a_o,
  output logic signed [fssm_pkg::COEF_W-1:0]       rd_b_o,
  output logic signed [fssm_pkg::COEF_W-1:0]       rd_c_o
);

  logic signed [fssm_pkg::COEF_W-1:0] mem_a [MAX_TERMS];
  logic signed [fssm_pkg::COEF_W-1:0] mem_b [MAX_TERMS];
  logic signed [fssm_pkg::COEF_W-1:0] mem_c [MAX_TERMS];

  logic [MAX_TERMS-1:0] vld_a_q, vld_b_q, vld_c_q;
  logic signed [fssm_pkg::COEF_W-1:0] rd_a_q, rd_b_q, rd_c_q;
  logic rd_va_q, rd_vb_q, rd_vc_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i.a) begin
      mem_a[wr_addr_i] <= wr_data_i;
    end
    if (wr_en_i.b) begin
      mem_b[wr_addr_i] <= wr_data_i;
    end
    if (wr_en_i.c) begin
      mem_c[wr_addr_i] <= wr_data_i;
    end
    rd_a_q <= mem_a[rd_addr_i];
    rd_b_q <= mem_b[rd_addr_i];
    rd_c_q <= mem_c[rd_addr_i];
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= '0;
      vld_b_q <= '0;
      vld_c_q <= '0;
      rd_va_q <= 1'b0;
      rd_vb_q <= 1'b0;
      rd_vc_q <= 1'b0;
    end else begin
      if (wr_en_i.a) begin
        vld_a_q[wr_addr_i] <= 1'b1;
      end
      if (wr_en_i.b) begin
        vld_b_q[wr_addr_i] <= 1'b1;
      end
      if (wr_en_i.c) begin
        vld_c_q[wr_addr_i] <= 1'b1;
      end
      rd_va_q <= vld_a_q[rd_addr_i];
      rd_vb_q <= vld_b_q[rd_addr_i];
      rd_vc_q <= vld_c_q[rd_addr_i];
    end
  end

  assign rd_a_o = rd_va_q ? rd_a_q : '0;
  assign rd_b_o = rd_vb_q ? rd_b_q : '0;
  assign rd_c_o = rd_vc_q ? rd_c_q : '0;

endmodule

`default_nettype wire

### sv/fourier_sine_series_morph_synth.sv
// loads, unused codes and a tick with animation off or zero terms skip the sweep
// select and a morphing tick sweep all MAX_TERMS table entries, one table entry per cycle
// evaluate sweeps n = min(num_terms, MAX_TERMS) terms on one multiplier, none when n is zero
// one request in flight at a time; the result register frees the input while it waits
// reset (rst_ni, async, active low) clears config, morph factor, direction (rising),
// control and the table valid bits so all three tables read as zero
`default_nettype none
`include "fourier_sine_series_morph_synth_assert.svh"

module fourier_sine_series_morph_synth #(
  parameter int MAX_TERMS          = fssm_pkg::MAX_TERMS_DEF,
  parameter int SINE_TABLE_ENTRIES = fssm_pkg::SINE_ENTRIES_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [fssm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [fssm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // command[2:0], term_index[7:3], coefficient[23:8], position[39:24]
  input  wire logic [fssm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // sample_value[20:0], morph_factor_out[37:21], zero fill[39:38]
  output logic [fssm_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

  localparam int AW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW   = $clog2(MAX_TERMS + 1);
  localparam int ACCW = 32 + CW;
  localparam int SW   = fssm_pkg::SAMPLE_W;
  localparam int FW   = fssm_pkg::FACTOR_W;
  localparam int MW   = fssm_pkg::MUL_W;
  localparam int PW   = fssm_pkg::PROD_W;
  localparam logic signed [ACCW-1:0] SAT_MAX = ACCW'((64'sd1 <<< (SW - 1)) - 1);
  localparam logic signed [ACCW-1:0] SAT_MIN = -ACCW'(64'sd1 <<< (SW - 1));

  // input fields
  fssm_pkg::cmd_e                  in_cmd;
  logic [4:0]                      in_index;
  logic signed [15:0]              in_coef;
  logic [15:0]                     in_pos;

  assign in_cmd   = fssm_pkg::cmd_e'(s_axis_tdata[2:0]);
  assign in_index = s_axis_tdata[7:3];
  assign in_coef  = signed'(s_axis_tdata[23:8]);
  assign in_pos   = s_axis_tdata[39:24];

  // configuration
  logic [fssm_pkg::NTERMS_W-1:0] num_terms_q;
  logic [fssm_pkg::STEP_W-1:0]   morph_step_q;
  logic                          anim_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_terms_q  <= '0;
      morph_step_q <= '0;
      anim_en_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (fssm_pkg::cfg_reg_e'(cfg_index_i))
        fssm_pkg::REG_NUM_TERMS:  num_terms_q  <= cfg_data_i[fssm_pkg::NTERMS_W-1:0];
        fssm_pkg::REG_MORPH_STEP: morph_step_q <= cfg_data_i[fssm_pkg::STEP_W-1:0];
        fssm_pkg::REG_ANIMATE:    anim_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer state
  fssm_pkg::state_e state_q, state_d;
  fssm_pkg::cmd_e   cmd_q;
  logic [CW-1:0]    cnt_q, limit_q, n_used, limit_d;
  logic [15:0]      pos_q, phase_q;
  logic [2:0]       pipe_q;
  logic [AW-1:0]    addr1_q, addr2_q;
  logic signed [15:0] coef2_q, b2_q;
  logic signed [ACCW-1:0] acc_q;
  logic [FW-1:0]    factor_q, factor_d;
  logic             rising_q, rising_d;
  logic             m_valid_q;
  logic [SW-1:0]    sample_q;
  logic [FW-1:0]    mfac_q;

  logic             accept, issue, out_load;
  fssm_pkg::wr_en_t wr_en;
  logic [AW-1:0]    wr_addr;
  logic signed [15:0] wr_data;
  logic [8:0]       idx_ext;
  logic [FW:0]      fac_sum;

  logic signed [15:0] rd_a, rd_b, rd_c, sine;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] blend_sum;
  logic signed [ACCW-1:0] rnd;
  logic [SW-1:0]    sample_d;

  always_comb begin
    if (32'(num_terms_q) > MAX_TERMS) begin
      n_used = CW'(MAX_TERMS);
    end else begin
      n_used = CW'(num_terms_q);
    end
  end

  assign s_axis_tready = (state_q == fssm_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign idx_ext       = 9'(in_index);
  assign fac_sum       = {1'b0, factor_q} + (FW + 1)'(morph_step_q);

  // next state, table writes and factor update
  always_comb begin
    state_d  = state_q;
    limit_d  = limit_q;
    factor_d = factor_q;
    rising_d = rising_q;
    issue    = 1'b0;
    out_load = 1'b0;
    wr_en    = '0;
    wr_addr  = addr1_q;
    wr_data  = rd_a;
    blend_sum = prod + (PW'(b2_q) <<< 16) + PW'(32768);
    unique case (state_q)
      fssm_pkg::ST_IDLE: begin
        wr_addr = idx_ext[AW-1:0];
        wr_data = in_coef;
        if (accept) begin
          state_d = fssm_pkg::ST_DONE;
          unique case (in_cmd)
            fssm_pkg::CMD_LOAD_A: begin
              wr_en.a = (idx_ext < 9'(MAX_TERMS));
              wr_en.c = (idx_ext < 9'(MAX_TERMS));
            end
            fssm_pkg::CMD_LOAD_B: begin
              wr_en.b = (idx_ext < 9'(MAX_TERMS));
            end
            fssm_pkg::CMD_SEL_A: begin
              factor_d = fssm_pkg::FACTOR_ONE;
              limit_d  = CW'(MAX_TERMS);
              state_d  = fssm_pkg::ST_SWEEP;
            end
            fssm_pkg::CMD_SEL_B: begin
              factor_d = '0;
              limit_d  = CW'(MAX_TERMS);
              state_d  = fssm_pkg::ST_SWEEP;
            end
            fssm_pkg::CMD_TICK: begin
              if (anim_en_q && num_terms_q != '0) begin
                // bounce off either end of [0, 1]
                if (rising_q) begin
                  if (fac_sum > (FW + 1)'(fssm_pkg::FACTOR_ONE)) begin
                    factor_d = fssm_pkg::FACTOR_ONE;
                    rising_d = 1'b0;
                  end else begin
                    factor_d = fac_sum[FW-1:0];
                  end
                end else begin
                  if (FW'(morph_step_q) > factor_q) begin
                    factor_d = '0;
                    rising_d = 1'b1;
                  end else begin
                    factor_d = factor_q - FW'(morph_step_q);
                  end
                end
                limit_d = CW'(MAX_TERMS);
                state_d = fssm_pkg::ST_SWEEP;
              end
            end
            fssm_pkg::CMD_EVAL: begin
              limit_d = n_used;
              state_d = fssm_pkg::ST_SWEEP;
            end
            default: ;
          endcase
        end
      end
      fssm_pkg::ST_SWEEP: begin
        issue = (cnt_q < limit_q);
        unique case (cmd_q)
          fssm_pkg::CMD_SEL_A: begin
            wr_en.c = pipe_q[0];
            wr_addr = addr1_q;
            wr_data = rd_a;
          end
          fssm_pkg::CMD_SEL_B: begin
            wr_en.c = pipe_q[0];
            wr_addr = addr1_q;
            wr_data = rd_b;
          end
          fssm_pkg::CMD_TICK: begin
            // f*A + (1-f)*B as B + f*(A-B), rounded
            wr_en.c = pipe_q[1];
            wr_addr = addr2_q;
            wr_data = blend_sum[31:16];
          end
          default: ;
        endcase
        if (!issue && pipe_q == '0) begin
          state_d = fssm_pkg::ST_DONE;
        end
      end
      fssm_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = fssm_pkg::ST_IDLE;
        end
      end
      default: state_d = fssm_pkg::ST_IDLE;
    endcase
  end

  // shared multiplier operands: blend in stage one, sine product in stage two
  always_comb begin
    if (cmd_q == fssm_pkg::CMD_EVAL) begin
      mul_a = MW'(coef2_q);
      mul_b = MW'(sine);
    end else begin
      mul_a = signed'({1'b0, factor_q});
      mul_b = MW'(rd_a) - MW'(rd_b);
    end
  end

  always_comb begin
    rnd = (acc_q + ACCW'(16384)) >>> 15;
    if (cmd_q != fssm_pkg::CMD_EVAL) begin
      sample_d = '0;
    end else if (rnd > SAT_MAX) begin
      sample_d = SAT_MAX[SW-1:0];
    end else if (rnd < SAT_MIN) begin
      sample_d = SAT_MIN[SW-1:0];
    end else begin
      sample_d = rnd[SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fssm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q     <= fssm_pkg::CMD_LOAD_A;
      cnt_q     <= '0;
      limit_q   <= '0;
      pipe_q    <= '0;
      factor_q  <= '0;
      rising_q  <= 1'b1;
      m_valid_q <= 1'b0;
    end else begin
      pipe_q   <= {pipe_q[1:0], issue};
      limit_q  <= limit_d;
      factor_q <= factor_d;
      rising_q <= rising_d;
      if (accept) begin
        cmd_q <= in_cmd;
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr1_q <= cnt_q[AW-1:0];
    addr2_q <= addr1_q;
    coef2_q <= rd_c;
    b2_q    <= rd_b;
    if (accept) begin
      pos_q   <= in_pos;
      phase_q <= in_pos;
      acc_q   <= '0;
    end else begin
      if (issue) begin
        phase_q <= phase_q + pos_q;
      end
      if (pipe_q[2]) begin
        acc_q <= acc_q + ACCW'(prod);
      end
    end
    if (out_load) begin
      sample_q <= sample_d;
      mfac_q   <= factor_q;
    end
  end

  fssm_coef_store #(
    .MAX_TERMS (MAX_TERMS),
    .AW        (AW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (cnt_q[AW-1:0]),
    .rd_a_o    (rd_a),
    .rd_b_o    (rd_b),
    .rd_c_o    (rd_c)
  );

  fssm_sine_rom #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
  ) u_sine (
    .clk_i   (clk_i),
    .phase_i (phase_q),
    .sine_o  (sine)
  );

  fssm_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, mfac_q, sample_q};

  `FSSM_ASSERT_NOW(a_factor_range, clk_i, rst_ni, 1'b1, factor_q <= fssm_pkg::FACTOR_ONE, "morph factor above one")
  `FSSM_ASSERT_NOW(a_idle_pipe_empty, clk_i, rst_ni, s_axis_tready, pipe_q == 3'b000, "request taken with terms in flight")
  `FSSM_ASSERT_NOW(a_eval_keeps_current, clk_i, rst_ni, state_q == fssm_pkg::ST_SWEEP && cmd_q == fssm_pkg::CMD_EVAL, !wr_en.c, "current set written during evaluate")
  `FSSM_ASSERT_NEXT(a_done_frees_input, clk_i, rst_ni, out_load, s_axis_tready && m_axis_tvalid, "result load did not return to idle")

endmodule

`default_nettype wire

### tb/sv/fourier_sine_series_morph_synth_tb.sv
`timescale 1ns / 1ps

module fourier_sine_series_morph_synth_tb;
  import fssm_pkg::*;

  localparam int TERMS          = MAX_TERMS_DEF;
  localparam int SINE_N         = SINE_ENTRIES_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 2 * TERMS + 16;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 118;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic [FACTOR_W-1:0]        factor;
  } synth_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]     cfg_data_i = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  // command[2:0], term_index[7:3], coefficient[23:8], position[39:24]
  logic [IN_TDATA_W-1:0]     s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  // sample_value[20:0], morph_factor_out[37:21], zero fill[39:38]
  logic [OUT_TDATA_W-1:0]    m_axis_tdata;

  // mirror of the block state
  int          sine_tab [0:SINE_N];
  int          coef_a [TERMS];
  int          coef_b [TERMS];
  int          coef_live [TERMS];
  int unsigned blend_factor;
  bit          blend_rising;
  int unsigned model_terms;
  int unsigned model_step;
  bit          model_anim;

  synth_result_t awaited_samples [$];
  int            fault_count = 0;
  int            quiet_cycles = 0;
  int unsigned   stall_left = 0;
  bit            steady_stream = 1'b0;

  fourier_sine_series_morph_synth u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // quarter-wave table, taylor series in q30
  function automatic void build_sine_table();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned s;
    longint unsigned v;
    for (int i = 0; i <= SINE_N; i++) begin
      x  = (longint'(i) * HALF_PI_Q30) / SINE_N;
      x2 = (x * x) >> 30;
      s  = ONE_Q30 - x2 / 110;
      s  = ONE_Q30 - ((x2 * s) >> 30) / 72;
      s  = ONE_Q30 - ((x2 * s) >> 30) / 42;
      s  = ONE_Q30 - ((x2 * s) >> 30) / 20;
      s  = ONE_Q30 - ((x2 * s) >> 30) / 6;
      s  = (x * s) >> 30;
      v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      sine_tab[i] = (v > 64'd32767) ? 32767 : int'(v);
    end
  endfunction

  function automatic int sine_of(input logic [PHASE_W-1:0] phase);
    logic [1:0]  quad;
    int unsigned frac;
    int unsigned idx;
    int          v;
    quad = phase[15:14];
    frac = quad[0] ? (16384 - phase[13:0]) : phase[13:0];
    idx  = (frac * SINE_N) >> 14;
    if (idx > SINE_N) begin
      idx = SINE_N;
    end
    v = sine_tab[idx];
    return quad[1] ? -v : v;
  endfunction

  function automatic synth_result_t synth_outcome(input logic [2:0] cmd,
                                                  input logic [4:0] idx,
                                                  input logic signed [15:0] coef,
                                                  input logic [15:0] pos);
    synth_result_t r;
    int unsigned   used;
    int unsigned   f;
    longint        acc;
    longint        v;
    logic [31:0]   ph;
    used = (model_terms > TERMS) ? TERMS : model_terms;
    acc  = 0;
    r.sample = '0;
    case (cmd)
      CMD_LOAD_A: begin
        coef_a[idx]    = coef;
        coef_live[idx] = coef;
      end
      CMD_LOAD_B: begin
        coef_b[idx] = coef;
      end
      CMD_SEL_A: begin
        coef_live    = coef_a;
        blend_factor = FACTOR_ONE;
      end
      CMD_SEL_B: begin
        coef_live    = coef_b;
        blend_factor = 0;
      end
      CMD_TICK: begin
        if (model_anim && used > 0) begin
          if (blend_rising) begin
            f = blend_factor + model_step;
            // only a value past one clamps and turns the direction
            if (f > FACTOR_ONE) begin
              f = FACTOR_ONE;
              blend_rising = 1'b0;
            end
            blend_factor = f;
          end else if (model_step > blend_factor) begin
            blend_factor = 0;
            blend_rising = 1'b1;
          end else begin
            blend_factor = blend_factor - model_step;
          end
          for (int i = 0; i < TERMS; i++) begin
            v = longint'(blend_factor) * coef_a[i]
              + longint'(FACTOR_ONE - blend_factor) * coef_b[i];
            coef_live[i] = int'((v + 32768) >>> 16);
          end
        end
      end
      CMD_EVAL: begin
        for (int k = 0; k < used; k++) begin
          ph  = (k + 1) * pos;
          acc = acc + longint'(coef_live[k]) * sine_of(ph[15:0]);
        end
        acc = (acc + 16384) >>> 15;
        if (acc > 1048575) begin
          acc = 1048575;
        end else if (acc < -1048576) begin
          acc = -1048576;
        end
        r.sample = acc[SAMPLE_W-1:0];
      end
      default: begin
      end
    endcase
    r.factor = blend_factor[FACTOR_W-1:0];
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_stream || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input logic [2:0] cmd, input logic [4:0] idx,
                              input logic [15:0] coef, input logic [15:0] pos);
    int unsigned   gap;
    synth_result_t outcome;
    gap = idle_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pos, coef, idx, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    outcome = synth_outcome(cmd, idx, coef, pos);
    awaited_samples.insert(awaited_samples.size(), outcome);
    @(negedge clk_i);
  endtask

  task automatic hold_until_settled();
    s_axis_tvalid <= 1'b0;
    while (awaited_samples.size() != 0) @(negedge clk_i);
  endtask

  task automatic configure(input int unsigned terms, input int unsigned step,
                           input bit anim);
    hold_until_settled();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_NUM_TERMS;
    cfg_data_i  <= 16'(terms);
    @(negedge clk_i);
    cfg_index_i <= REG_MORPH_STEP;
    cfg_data_i  <= 16'(step);
    @(negedge clk_i);
    cfg_index_i <= REG_ANIMATE;
    cfg_data_i  <= {15'd0, anim};
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    model_terms = terms & 63;
    model_step  = step & 16'hFFFF;
    model_anim  = anim;
  endtask

  function automatic logic [15:0] pick_coef();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_position();
    int unsigned r;
    r = $urandom_range(0, 29);
    case (r)
      0: return 16'h0000;
      1: return 16'h4000;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return 16'hC000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_terms();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return TERMS;
      3: return 63;
      4: return $urandom_range(TERMS + 1, 63);
      default: return $urandom_range(1, TERMS);
    endcase
  endfunction

  function automatic int unsigned pick_step();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 65535;
      2: return 1;
      3, 4, 5: return $urandom_range(512, 8192);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_request(CMD_EVAL, 5'($urandom), 16'($urandom), 16'h4000);
    send_request(CMD_TICK, 5'($urandom), 16'($urandom), 16'($urandom));
    // unused command codes leave everything alone
    send_request(3'd6, 5'd31, 16'hFFFF, 16'hFFFF);
    send_request(3'd7, 5'd0, 16'h0000, 16'h0000);
  endtask

  task automatic test_extreme_coefficients();
    configure(TERMS, 0, 1'b0);
    send_request(CMD_LOAD_A, 5'd0, 16'h7FFF, 16'($urandom));
    send_request(CMD_LOAD_A, 5'd31, 16'h8000, 16'($urandom));
    send_request(CMD_LOAD_A, 5'd1, 16'h0100, 16'($urandom));
    send_request(CMD_EVAL, 5'($urandom), 16'($urandom), 16'h4000);
    send_request(CMD_EVAL, 5'($urandom), 16'($urandom), 16'h8000);
    send_request(CMD_EVAL, 5'($urandom), 16'($urandom), 16'h7FFF);
    // more terms than the tables hold
    configure(63, 0, 1'b0);
    send_request(CMD_EVAL, 5'($urandom), 16'($urandom), 16'h2000);
  endtask

  task automatic test_set_select();
    send_request(CMD_LOAD_B, 5'd0, 16'h8000, 16'($urandom));
    send_request(CMD_LOAD_B, 5'd31, 16'h7FFF, 16'($urandom));
    send_request(CMD_SEL_B, 5'($urandom), 16'($urandom), 16'($urandom));
    send_request(CMD_EVAL, 5'($urandom), 16'($urandom), 16'h4000);
    send_request(CMD_SEL_A, 5'($urandom), 16'($urandom), 16'($urandom));
    send_request(CMD_EVAL, 5'($urandom), 16'($urandom), 16'hC000);
  endtask

  task automatic test_morph_bounce();
    configure(TERMS, 16384, 1'b1);
    send_request(CMD_SEL_B, 5'($urandom), 16'($urandom), 16'($urandom));
    // reaches one exactly, then clamps on the next tick
    repeat (5) send_request(CMD_TICK, 5'($urandom), 16'($urandom), 16'($urandom));
    send_request(CMD_EVAL, 5'($urandom), 16'($urandom), 16'h1000);
    configure(TERMS, 65535, 1'b1);
    repeat (3) send_request(CMD_TICK, 5'($urandom), 16'($urandom), 16'($urandom));
    send_request(CMD_EVAL, 5'($urandom), 16'($urandom), 16'h0800);
    // no terms in use: tick must not move the factor
    configure(0, 65535, 1'b1);
    send_request(CMD_TICK, 5'($urandom), 16'($urandom), 16'($urandom));
    configure(TERMS, 0, 1'b1);
    send_request(CMD_TICK, 5'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic test_random_morph();
    int unsigned loads;
    int unsigned r;
    logic [2:0]  cmd;
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        configure(TERMS, 65535, 1'b1);
      end else if (p == 1) begin
        configure(63, 1, 1'b1);
      end else begin
        configure(pick_terms(), pick_step(), 1'($urandom));
      end
      steady_stream = (p == 3);
      loads = $urandom_range(4, 24);
      // fill the sets first, each load into A or B at random, so the morph has something to blend
      for (int i = 0; i < loads; i++) begin
        cmd = $urandom_range(0, 1) ? CMD_LOAD_A : CMD_LOAD_B;
        send_request(cmd, 5'($urandom), pick_coef(), 16'($urandom));
      end
      cmd = $urandom_range(0, 1) ? CMD_SEL_A : CMD_SEL_B;
      send_request(cmd, 5'($urandom), 16'($urandom), 16'($urandom));
      for (int i = loads + 1; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 15) cmd = CMD_LOAD_A;
        else if (r < 30) cmd = CMD_LOAD_B;
        else if (r < 35) cmd = CMD_SEL_A;
        else if (r < 40) cmd = CMD_SEL_B;
        else if (r < 70) cmd = CMD_TICK;
        else if (r < 95) cmd = CMD_EVAL;
        else cmd = 3'($urandom_range(6, 7));
        send_request(cmd, 5'($urandom), pick_coef(), pick_position());
        if ($urandom_range(0, 39) == 0) begin
          hold_until_settled();
        end
      end
    end
    steady_stream = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = idle_gap();
    end
  end

  always @(posedge clk_i) begin : check_results
    synth_result_t got;
    synth_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.sample = m_axis_tdata[SAMPLE_W-1:0];
      got.factor = m_axis_tdata[SAMPLE_W+FACTOR_W-1:SAMPLE_W];
      if (awaited_samples.size() == 0) begin
        if (fault_count < 10) begin
          $display("%0t: unexpected result sample %0d factor %0d",
                   $realtime, got.sample, got.factor);
        end
        fault_count++;
      end else begin
        want = awaited_samples.pop_front();
        if (got.sample !== want.sample || got.factor !== want.factor) begin
          if (fault_count < 10) begin
            $display("%0t: sample exp %0d got %0d, factor exp %0d got %0d",
                     $realtime, want.sample, got.sample, want.factor, got.factor);
          end
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    build_sine_table();
    for (int i = 0; i < TERMS; i++) begin
      coef_a[i]    = 0;
      coef_b[i]    = 0;
      coef_live[i] = 0;
    end
    blend_factor = 0;
    blend_rising = 1'b1;
    model_terms  = 0;
    model_step   = 0;
    model_anim   = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_extreme_coefficients();
    test_set_select();
    test_morph_bounce();
    test_random_morph();
    hold_until_settled();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fault_count == 0 && awaited_samples.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
